// ----- rtl/pdcb_pkg.sv -----
// Shared types, constants and codes of the per-destination coalescing buffer.
`default_nettype none

package pdcb_pkg;

	localparam int DEST_W     = 4;
	localparam int WORD_W     = 64;
	localparam int LEN_W      = 7;
	localparam int TAG_W      = 8;
	localparam int RANK_W     = 4;
	localparam int STATUS_W   = 2;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 7;

	localparam int RANKS_DEFAULT    = 16;
	localparam int CAPACITY_DEFAULT = 64;

	localparam logic [LEN_W-1:0] EAGER_RESET = LEN_W'(64);

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_EAGER = 1'b0,
		CFG_RANK  = 1'b1
	} cfg_idx_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_APPENDED = 2'd0,
		ST_OVERFLOW = 2'd1,
		ST_NOFLUSH  = 2'd2,
		ST_FLUSHED  = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		K_APPEND     = 2'd0,
		K_FLUSH      = 2'd1,
		K_BAD_APPEND = 2'd2,
		K_BAD_FLUSH  = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		B_IDLE = 3'd0,
		B_EVAL = 3'd1,
		B_DIV  = 3'd2,
		B_READ = 3'd3,
		B_WORD = 3'd4,
		B_SEND = 3'd5
	} state_t;

	typedef struct packed {
		kind_t              kind;
		logic [DEST_W-1:0]  dest;
		logic [WORD_W-1:0]  word;
		logic [LEN_W-1:0]   period;
		logic [TAG_W-1:0]   tag;
		logic               force_req;
	} cmd_t;

	typedef struct packed {
		logic               start;
		logic [LEN_W-1:0]   dividend;
		logic [LEN_W-1:0]   divisor;
	} div_req_t;

	typedef struct packed {
		logic               done;
		logic [LEN_W-1:0]   rem;
	} div_rsp_t;

endpackage

`default_nettype wire

// ----- rtl/pdcb_if.sv -----
// Valid/ready channel interfaces for the input items and the result words.
`default_nettype none

interface pdcb_in_if;
	logic                          valid;
	logic                          ready;
	logic                          func;
	logic [pdcb_pkg::DEST_W-1:0]   destination;
	logic [pdcb_pkg::WORD_W-1:0]   word;
	logic [pdcb_pkg::LEN_W-1:0]    period;
	logic [pdcb_pkg::TAG_W-1:0]    tag;
	logic                          force_req;

	modport source (output valid, func, destination, word, period, tag, force_req,
		input ready);
	modport sink (input valid, func, destination, word, period, tag, force_req,
		output ready);
endinterface

interface pdcb_out_if;
	logic                          valid;
	logic                          ready;
	logic [pdcb_pkg::STATUS_W-1:0] status;
	logic [pdcb_pkg::DEST_W-1:0]   dest_out;
	logic [pdcb_pkg::RANK_W-1:0]   source_rank;
	logic [pdcb_pkg::TAG_W-1:0]    tag_out;
	logic [pdcb_pkg::WORD_W-1:0]   data_out;
	logic [pdcb_pkg::LEN_W-1:0]    message_length;
	logic                          last;

	modport source (output valid, status, dest_out, source_rank, tag_out, data_out,
		message_length, last, input ready);
	modport sink (input valid, status, dest_out, source_rank, tag_out, data_out,
		message_length, last, output ready);
endinterface

`default_nettype wire

// ----- rtl/pdcb_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
`default_nettype none

module pdcb_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 1024
) (
	input  wire logic                                   clk,
	input  wire logic                                   we,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                       wdata,
	input  wire logic                                   re,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

// ----- rtl/pdcb_front.sv -----
// Front part: accepts input words, classifies them and queues commands.
`default_nettype none

module pdcb_front #(
	parameter int RANKS = pdcb_pkg::RANKS_DEFAULT
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	pdcb_in_if.sink       in,
	output pdcb_pkg::cmd_t head,
	output logic          head_valid,
	input  wire logic     pop
);

	localparam int QDepth = 2;
	localparam int PtrW   = $clog2(QDepth);
	localparam int CntW   = $clog2(QDepth + 1);

	pdcb_pkg::cmd_t  queue_q [QDepth];
	pdcb_pkg::cmd_t  cmd_new;
	logic [PtrW-1:0] wptr_q;
	logic [PtrW-1:0] rptr_q;
	logic [CntW-1:0] cnt_q;
	logic            push;
	logic            in_range;

	assign in.ready   = (cnt_q != CntW'(QDepth));
	assign push       = in.valid & in.ready;
	assign head       = queue_q[rptr_q];
	assign head_valid = (cnt_q != '0);

	// A destination at or above the rank count touches no state.
	assign in_range = (32'(in.destination) < RANKS);

	always_comb begin
		cmd_new.dest      = in.destination;
		cmd_new.word      = in.word;
		cmd_new.period    = in.period;
		cmd_new.tag       = in.tag;
		cmd_new.force_req = in.force_req;
		if (in.func) begin
			cmd_new.kind = in_range ? pdcb_pkg::K_FLUSH : pdcb_pkg::K_BAD_FLUSH;
		end else begin
			cmd_new.kind = in_range ? pdcb_pkg::K_APPEND : pdcb_pkg::K_BAD_APPEND;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			queue_q[wptr_q] <= cmd_new;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (push) begin
				wptr_q <= PtrW'(wptr_q + 1'b1);
			end
			if (pop) begin
				rptr_q <= PtrW'(rptr_q + 1'b1);
			end
			case ({push, pop})
				2'b10:   cnt_q <= CntW'(cnt_q + 1'b1);
				2'b01:   cnt_q <= CntW'(cnt_q - 1'b1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

`default_nettype wire

// ----- rtl/pdcb_div.sv -----
// Restoring divider that returns the remainder, one quotient bit per cycle.
`default_nettype none

module pdcb_div (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire pdcb_pkg::div_req_t req,
	output pdcb_pkg::div_rsp_t rsp
);

	localparam int W    = pdcb_pkg::LEN_W;
	localparam int CntW = $clog2(W + 1);

	logic [W-1:0]    rem_q;
	logic [W-1:0]    dvd_q;
	logic [W-1:0]    dsr_q;
	logic [CntW-1:0] cnt_q;
	logic            act_q;
	logic [W:0]      part;
	logic [W-1:0]    rem_d;

	assign part = {rem_q, dvd_q[W-1]};

	always_comb begin
		if (part >= {1'b0, dsr_q}) begin
			rem_d = W'(part - {1'b0, dsr_q});
		end else begin
			rem_d = part[W-1:0];
		end
	end

	assign rsp.done = act_q && (cnt_q == '0);
	assign rsp.rem  = rem_q;

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			dvd_q <= req.dividend;
			dsr_q <= req.divisor;
		end else if (act_q && (cnt_q != '0)) begin
			rem_q <= rem_d;
			dvd_q <= {dvd_q[W-2:0], 1'b0};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q <= 1'b0;
			cnt_q <= '0;
		end else if (req.start) begin
			act_q <= 1'b1;
			cnt_q <= CntW'(W);
		end else if (act_q) begin
			if (cnt_q == '0) begin
				act_q <= 1'b0;
			end else begin
				cnt_q <= CntW'(cnt_q - 1'b1);
			end
		end
	end

endmodule

`default_nettype wire

// ----- rtl/pdcb_back.sv -----
// Back part: sequencer that updates fill counts, stores words and streams flushes.
`default_nettype none

module pdcb_back #(
	parameter int RANKS    = pdcb_pkg::RANKS_DEFAULT,
	parameter int CAPACITY = pdcb_pkg::CAPACITY_DEFAULT
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire pdcb_pkg::cmd_t                head,
	input  wire logic                          head_valid,
	output logic                               pop,
	input  wire logic [pdcb_pkg::LEN_W-1:0]    eager,
	input  wire logic [pdcb_pkg::RANK_W-1:0]   sender_rank,
	pdcb_out_if.source                         out
);

	localparam int RankAW = (RANKS > 1) ? $clog2(RANKS) : 1;
	localparam int FillW  = $clog2(CAPACITY + 1);
	localparam int Depth  = RANKS * CAPACITY;
	localparam int WordAW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int LenW   = pdcb_pkg::LEN_W;
	localparam int WordW  = pdcb_pkg::WORD_W;

	pdcb_pkg::state_t  state_q, state_d;
	pdcb_pkg::cmd_t    cmd_q;
	pdcb_pkg::div_req_t div_req;
	pdcb_pkg::div_rsp_t div_rsp;

	logic [FillW-1:0]  fill_q;
	logic [FillW-1:0]  idx_q;
	logic [RANKS-1:0]  vld_q;
	logic [FillW-1:0]  fill_rd;
	logic [FillW-1:0]  fill_cur;
	logic [WordW-1:0]  word_rd;
	logic [RankAW-1:0] didx;
	logic              full;
	logic              below_cur;
	logic              below_div;
	logic              last_word;
	logic              out_take;

	logic              fill_re, fill_we;
	logic [FillW-1:0]  fill_wdata;
	logic              word_re, word_we;
	logic [WordAW-1:0] word_waddr, word_raddr;
	logic              vld_set, vld_clr;

	logic                         ld;
	pdcb_pkg::status_t            ld_status;
	logic [LenW-1:0]              ld_len;
	logic [pdcb_pkg::TAG_W-1:0]   ld_tag;
	logic [WordW-1:0]             ld_data;
	logic                         ld_last;

	logic                         ovld_q;
	pdcb_pkg::status_t            st_q;
	logic [pdcb_pkg::DEST_W-1:0]  dest_q;
	logic [pdcb_pkg::RANK_W-1:0]  rank_q;
	logic [pdcb_pkg::TAG_W-1:0]   tag_q;
	logic [WordW-1:0]             data_q;
	logic [LenW-1:0]              len_q;
	logic                         last_q;

	assign didx      = RankAW'(cmd_q.dest);
	assign fill_cur  = vld_q[didx] ? fill_rd : '0;
	assign full      = (32'(fill_cur) >= CAPACITY);
	assign below_cur = (LenW'(fill_cur) < eager);
	assign below_div = (LenW'(fill_q) < LenW'(eager - div_rsp.rem));
	assign last_word = (FillW'(idx_q + 1'b1) == fill_q);
	assign out_take  = ovld_q & out.ready;

	assign word_waddr = WordAW'(WordAW'(cmd_q.dest) * WordAW'(CAPACITY) + WordAW'(fill_cur));
	assign word_raddr = WordAW'(WordAW'(cmd_q.dest) * WordAW'(CAPACITY) + WordAW'(idx_q));
	assign fill_wdata = FillW'(fill_cur + 1'b1);

	pdcb_ram #(
		.WIDTH (FillW),
		.DEPTH (RANKS)
	) u_fill_ram (
		.clk   (clk),
		.we    (fill_we),
		.waddr (didx),
		.wdata (fill_wdata),
		.re    (fill_re),
		.raddr (RankAW'(head.dest)),
		.rdata (fill_rd)
	);

	pdcb_ram #(
		.WIDTH (WordW),
		.DEPTH (Depth)
	) u_word_ram (
		.clk   (clk),
		.we    (word_we),
		.waddr (word_waddr),
		.wdata (cmd_q.word),
		.re    (word_re),
		.raddr (word_raddr),
		.rdata (word_rd)
	);

	pdcb_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	always_comb begin
		state_d = state_q;
		case (state_q)
			pdcb_pkg::B_IDLE: begin
				if (head_valid) begin
					state_d = pdcb_pkg::B_EVAL;
				end
			end
			pdcb_pkg::B_EVAL: begin
				case (cmd_q.kind)
					pdcb_pkg::K_FLUSH: begin
						if (fill_cur == '0) begin
							state_d = pdcb_pkg::B_SEND;
						end else if (cmd_q.force_req) begin
							state_d = pdcb_pkg::B_READ;
						end else if (cmd_q.period == '0) begin
							state_d = below_cur ? pdcb_pkg::B_SEND : pdcb_pkg::B_READ;
						end else begin
							state_d = pdcb_pkg::B_DIV;
						end
					end
					default: state_d = pdcb_pkg::B_SEND;
				endcase
			end
			pdcb_pkg::B_DIV: begin
				if (div_rsp.done) begin
					state_d = below_div ? pdcb_pkg::B_SEND : pdcb_pkg::B_READ;
				end
			end
			pdcb_pkg::B_READ: state_d = pdcb_pkg::B_WORD;
			pdcb_pkg::B_WORD: state_d = pdcb_pkg::B_SEND;
			pdcb_pkg::B_SEND: begin
				if (out_take) begin
					state_d = last_q ? pdcb_pkg::B_IDLE : pdcb_pkg::B_READ;
				end
			end
			default: state_d = pdcb_pkg::B_IDLE;
		endcase
	end

	always_comb begin
		pop              = 1'b0;
		fill_re          = 1'b0;
		fill_we          = 1'b0;
		word_re          = 1'b0;
		word_we          = 1'b0;
		vld_set          = 1'b0;
		vld_clr          = 1'b0;
		div_req.start    = 1'b0;
		div_req.dividend = eager;
		div_req.divisor  = cmd_q.period;
		ld               = 1'b0;
		ld_status        = pdcb_pkg::ST_NOFLUSH;
		ld_len           = '0;
		ld_tag           = '0;
		ld_data          = '0;
		ld_last          = 1'b1;
		case (state_q)
			pdcb_pkg::B_IDLE: begin
				pop     = head_valid;
				fill_re = head_valid;
			end
			pdcb_pkg::B_EVAL: begin
				case (cmd_q.kind)
					pdcb_pkg::K_BAD_APPEND: begin
						ld        = 1'b1;
						ld_status = pdcb_pkg::ST_OVERFLOW;
					end
					pdcb_pkg::K_BAD_FLUSH: begin
						ld        = 1'b1;
						ld_status = pdcb_pkg::ST_NOFLUSH;
					end
					pdcb_pkg::K_APPEND: begin
						ld = 1'b1;
						if (full) begin
							ld_status = pdcb_pkg::ST_OVERFLOW;
							ld_len    = LenW'(fill_cur);
						end else begin
							word_we   = 1'b1;
							fill_we   = 1'b1;
							vld_set   = 1'b1;
							ld_status = pdcb_pkg::ST_APPENDED;
							ld_len    = LenW'(fill_wdata);
						end
					end
					pdcb_pkg::K_FLUSH: begin
						if (fill_cur == '0) begin
							ld = 1'b1;
						end else if (cmd_q.force_req) begin
							vld_clr = 1'b1;
						end else if (cmd_q.period == '0) begin
							if (below_cur) begin
								ld     = 1'b1;
								ld_len = LenW'(fill_cur);
							end else begin
								vld_clr = 1'b1;
							end
						end else begin
							div_req.start = 1'b1;
						end
					end
					default: ld = 1'b1;
				endcase
			end
			pdcb_pkg::B_DIV: begin
				if (div_rsp.done) begin
					if (below_div) begin
						ld     = 1'b1;
						ld_len = LenW'(fill_q);
					end else begin
						vld_clr = 1'b1;
					end
				end
			end
			pdcb_pkg::B_READ: word_re = 1'b1;
			pdcb_pkg::B_WORD: begin
				ld        = 1'b1;
				ld_status = pdcb_pkg::ST_FLUSHED;
				ld_len    = LenW'(fill_q);
				ld_tag    = cmd_q.tag;
				ld_data   = word_rd;
				ld_last   = last_word;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cmd_q <= head;
		end
		if (state_q == pdcb_pkg::B_EVAL) begin
			fill_q <= fill_cur;
		end
		if (ld) begin
			st_q   <= ld_status;
			dest_q <= cmd_q.dest;
			rank_q <= sender_rank;
			tag_q  <= ld_tag;
			data_q <= ld_data;
			len_q  <= ld_len;
			last_q <= ld_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pdcb_pkg::B_IDLE;
			vld_q   <= '0;
			idx_q   <= '0;
			ovld_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (vld_set) begin
				vld_q[didx] <= 1'b1;
			end else if (vld_clr) begin
				vld_q[didx] <= 1'b0;
			end
			if (vld_clr) begin
				idx_q <= '0;
			end else if (out_take && !last_q) begin
				idx_q <= FillW'(idx_q + 1'b1);
			end
			if (ld) begin
				ovld_q <= 1'b1;
			end else if (out_take) begin
				ovld_q <= 1'b0;
			end
		end
	end

	assign out.valid          = ovld_q;
	assign out.status         = st_q;
	assign out.dest_out       = dest_q;
	assign out.source_rank    = rank_q;
	assign out.tag_out        = tag_q;
	assign out.data_out       = data_q;
	assign out.message_length = len_q;
	assign out.last           = last_q;

	a_send_holds_word: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == pdcb_pkg::B_SEND) |-> ovld_q)
		else $error("sequencer waits for a word that is not loaded");

	a_no_store_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		word_we |-> !full)
		else $error("word stored into a full buffer");

	a_div_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		div_req.start |-> (cmd_q.period != '0))
		else $error("threshold division started with a zero period");

	a_flush_has_length: assert property (@(posedge clk) disable iff (!arst_n)
		(ovld_q && (st_q == pdcb_pkg::ST_FLUSHED)) |-> (len_q != '0))
		else $error("flushed word carries an empty message length");

endmodule

`default_nettype wire

// ----- rtl/per_destination_coalescing_buffer_core.sv -----
// Top level of the per-destination coalescing buffer: configuration registers and the two parts.
`default_nettype none

// The block keeps a buffer of up to CAPACITY 64-bit words and a fill count for each of RANKS
// destinations. An append word stores its data at the end of the addressed buffer and returns
// one acknowledgement; a full buffer drops the data and answers with an overflow status. A flush
// word compares the fill with the eager limit rounded down to a multiple of the period (a forced
// flush skips the comparison) and, if the buffer is not empty and the fill is not below that
// limit, streams the stored words in order with the last one marked, then empties the buffer;
// otherwise it answers "not flushed". The front part takes input words into a two-entry
// command queue, so the input side keeps moving while a result waits on the output register.
// The back part is a sequencer that handles one command at a time. An unforced flush of a
// non-empty buffer with a non-zero period first runs the bit-serial threshold division. Each
// streamed word passes through the registered read of the word memory and then the output
// register. Fill counts sit in a small memory with one valid bit per destination, cleared at
// reset, so there is no clearing pass and the block accepts words straight out of reset.
// Configuration may be written only while the block is idle.
module per_destination_coalescing_buffer_core #(
	parameter int RANKS    = pdcb_pkg::RANKS_DEFAULT,
	parameter int CAPACITY = pdcb_pkg::CAPACITY_DEFAULT
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	pdcb_in_if.sink                                  in,
	pdcb_out_if.source                               out,
	input  wire logic                                cfg_we,
	input  wire logic [pdcb_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire logic [pdcb_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

	logic [pdcb_pkg::LEN_W-1:0]  eager_q;
	logic [pdcb_pkg::RANK_W-1:0] rank_q;
	pdcb_pkg::cmd_t              head;
	logic                        head_valid;
	logic                        pop;

	// Configuration registers; the eager limit resets to a full 64-word message.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eager_q <= pdcb_pkg::EAGER_RESET;
			rank_q  <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				pdcb_pkg::CFG_EAGER: eager_q <= cfg_wdata[pdcb_pkg::LEN_W-1:0];
				pdcb_pkg::CFG_RANK:  rank_q  <= cfg_wdata[pdcb_pkg::RANK_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// The front classifies each word (append or flush, destination in range or not) and
	// queues it; the back pops one command whenever it is free.
	pdcb_front #(
		.RANKS (RANKS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in         (in),
		.head       (head),
		.head_valid (head_valid),
		.pop        (pop)
	);

	pdcb_back #(
		.RANKS    (RANKS),
		.CAPACITY (CAPACITY)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head        (head),
		.head_valid  (head_valid),
		.pop         (pop),
		.eager       (eager_q),
		.sender_rank (rank_q),
		.out         (out)
	);

endmodule

`default_nettype wire
